FILE: rtl/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg: shared types and constants of the header line parser
// Byte classes, result kinds, counter widths and the key length clamp.
// ----------------------------------------------------------------------------
package hhlp_pkg;

   // Counter and field widths
   localparam int KEY_COUNT_BITS = 10;
   localparam int KEY_LEN_W      = 10;
   localparam int VALUE_LEN_W    = 11;
   localparam int MAX_OFFSET_W   = 10;
   localparam int KEY_SAT_W      = (KEY_COUNT_BITS > KEY_LEN_W) ? KEY_COUNT_BITS : KEY_LEN_W;

   localparam logic [KEY_COUNT_BITS-1:0] KEY_COUNT_MAX   = '1;
   localparam logic [KEY_LEN_W-1:0]      KEY_LEN_MAX     = '1;
   localparam logic [MAX_OFFSET_W-1:0]   MAX_OFFSET_INIT = MAX_OFFSET_W'(255);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Characters of interest
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_SKIP   = 3'd0,
      KIND_KEY    = 3'd1,
      KIND_SEP    = 3'd2,
      KIND_VALUE  = 3'd3,
      KIND_COMMIT = 3'd4,
      KIND_DONE   = 3'd5,
      KIND_ERROR  = 3'd6,
      KIND_BODY   = 3'd7
   } kind_type;

   // One classified byte, as the front hands it to the back
   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
      logic       is_space;
   } item_type;

   // One result
   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               data;
      logic [KEY_LEN_W-1:0]     key_len;
      logic [VALUE_LEN_W-1:0]   value_len;
   } result_type;

   // Clamp the key counter to the width of the reported key length
   function automatic logic [KEY_LEN_W-1:0] key_len_sat(input logic [KEY_COUNT_BITS-1:0] kc);
      logic [KEY_SAT_W-1:0] wide;
      wide = KEY_SAT_W'(kc);
      if (wide > KEY_SAT_W'(KEY_LEN_MAX)) begin
         return KEY_LEN_MAX;
      end
      return KEY_LEN_W'(wide);
   endfunction

endpackage

FILE: rtl/http_header_line_parser.sv
// ----------------------------------------------------------------------------
// http_header_line_parser: HTTP header byte tagger
// Each byte's result is registered through the front register, the queue and
// the result register. Throughput: one byte per cycle, as long as the sink
// keeps rsp_tready high. Reset is synchronous: phase to start, counters and
// queue cleared, max_value_offset back to 255.
// ----------------------------------------------------------------------------
module http_header_line_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration
   input  logic                                 csr_wr_en,
   input  logic [hhlp_pkg::MAX_OFFSET_W-1:0]    csr_wr_data,  // max_value_offset
   // Input bytes
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,    // [7:0] byte_in
   input  logic                                 req_tuser,    // [0] restart
   // Results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] out_byte, [17:8] key_length, [28:18] value_length, [31:29] zero
   output logic [31:0]                          rsp_tdata,
   output logic [2:0]                           rsp_tuser     // [2:0] out_kind
);

   logic                  push, push_ready;
   hhlp_pkg::item_type    push_item;
   logic                  pop_valid, pop;
   hhlp_pkg::item_type    pop_item;
   hhlp_pkg::result_type  result;

   hhlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_restart (req_tuser),
      .push       (push),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   hhlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   hhlp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg_wr_en    (csr_wr_en),
      .cfg_wr_data  (csr_wr_data),
      .item_valid   (pop_valid),
      .pop          (pop),
      .item         (pop_item),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   // Pack the result fields
   assign rsp_tdata = {3'b000, result.value_len, result.key_len, result.data};
   assign rsp_tuser = result.kind;

endmodule

FILE: rtl/hhlp_front.sv
// ----------------------------------------------------------------------------
// hhlp_front: input stage of the header line parser
// Accepts one byte per transfer, classifies it and offers it to the queue.
// ----------------------------------------------------------------------------
module hhlp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_restart,
   output logic                push,
   input  logic                push_ready,
   output hhlp_pkg::item_type  push_item
);

   logic               valid_ff, valid_in;
   hhlp_pkg::item_type item_ff, item_in;
   logic               take;

   // Take a new byte when the stage is empty or drains this cycle
   assign in_ready  = !valid_ff || push_ready;
   assign take      = in_valid && in_ready;
   assign push      = valid_ff;
   assign push_item = item_ff;

   // Classify the incoming byte
   always_comb begin
      item_in.data     = in_byte;
      item_in.restart  = in_restart;
      item_in.is_cr    = (in_byte == hhlp_pkg::CHAR_CR);
      item_in.is_lf    = (in_byte == hhlp_pkg::CHAR_LF);
      item_in.is_colon = (in_byte == hhlp_pkg::CHAR_COLON);
      item_in.is_space = (in_byte == hhlp_pkg::CHAR_SPACE);
   end

   // Hold the stage until the queue takes it
   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: rtl/hhlp_queue.sv
// ----------------------------------------------------------------------------
// hhlp_queue: short FIFO between front and back
// Lets the front keep taking bytes while the back waits on the result side.
// ----------------------------------------------------------------------------
module hhlp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                push_ready,
   input  hhlp_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop,
   output hhlp_pkg::item_type  pop_item
);

   hhlp_pkg::item_type                     entry_ff [hhlp_pkg::QUEUE_DEPTH];
   logic [hhlp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hhlp_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hhlp_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                   do_push, do_pop;

   localparam logic [hhlp_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      hhlp_pkg::QUEUE_PTR_W'(hhlp_pkg::QUEUE_DEPTH - 1);
   localparam logic [hhlp_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      hhlp_pkg::QUEUE_CNT_W'(hhlp_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill level beyond depth");

   // A push into a full queue that does not drain is refused
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_FULL && !pop) |=> (count_ff == CNT_FULL))
      else $error("queue full level lost without a pop");

endmodule

FILE: rtl/hhlp_back.sv
// ----------------------------------------------------------------------------
// hhlp_back: phase machine and result register of the header line parser
// Updates the parse phase and the two length counters per byte, tags it.
// ----------------------------------------------------------------------------
module hhlp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cfg_wr_en,
   input  logic [hhlp_pkg::MAX_OFFSET_W-1:0]     cfg_wr_data,
   input  logic                                  item_valid,
   output logic                                  pop,
   input  hhlp_pkg::item_type                    item,
   output logic                                  result_valid,
   input  logic                                  result_ready,
   output hhlp_pkg::result_type                  result
);

   typedef enum logic [9:0] {
      PH_START  = 10'b00_0000_0001,
      PH_KEY    = 10'b00_0000_0010,
      PH_COLON  = 10'b00_0000_0100,
      PH_SPACE  = 10'b00_0000_1000,
      PH_VALUE  = 10'b00_0001_0000,
      PH_CR     = 10'b00_0010_0000,
      PH_LF     = 10'b00_0100_0000,
      PH_END_CR = 10'b00_1000_0000,
      PH_DONE   = 10'b01_0000_0000,
      PH_ERROR  = 10'b10_0000_0000
   } phase_type;

   phase_type                                phase_ff, phase_in, cur_phase;
   logic [hhlp_pkg::KEY_COUNT_BITS-1:0]      key_count_ff, key_count_in, cur_key;
   logic [hhlp_pkg::VALUE_LEN_W-1:0]         value_count_ff, value_count_in, cur_value;
   logic [hhlp_pkg::MAX_OFFSET_W-1:0]        max_offset_ff;
   logic                                     result_valid_ff, result_valid_in;
   hhlp_pkg::result_type                     result_ff, result_in;

   // Step when a byte waits and the result register is free
   assign pop          = item_valid && (!result_valid_ff || result_ready);
   assign result_valid = result_valid_ff;
   assign result       = result_ff;

   // Phase update and tagging for the byte at the head of the queue
   always_comb begin
      cur_phase = item.restart ? PH_START : phase_ff;
      cur_key   = item.restart ? '0 : key_count_ff;
      cur_value = item.restart ? '0 : value_count_ff;

      phase_in       = cur_phase;
      key_count_in   = cur_key;
      value_count_in = cur_value;

      result_in.kind      = hhlp_pkg::KIND_ERROR;
      result_in.data      = item.data;
      result_in.key_len   = '0;
      result_in.value_len = '0;

      unique case (cur_phase)
         PH_START: begin
            if (item.is_cr || item.is_lf) begin
               result_in.kind = hhlp_pkg::KIND_SKIP;
            end else begin
               key_count_in   = hhlp_pkg::KEY_COUNT_BITS'(1);
               value_count_in = '0;
               phase_in       = PH_KEY;
               result_in.kind = hhlp_pkg::KIND_KEY;
            end
         end
         PH_KEY: begin
            if (item.is_colon) begin
               phase_in       = PH_COLON;
               result_in.kind = hhlp_pkg::KIND_SEP;
            end else if (item.is_cr || item.is_lf) begin
               phase_in = PH_ERROR;
            end else begin
               if (cur_key != hhlp_pkg::KEY_COUNT_MAX) begin
                  key_count_in = cur_key + 1'b1;
               end
               result_in.kind = hhlp_pkg::KIND_KEY;
            end
         end
         PH_COLON: begin
            if (item.is_space) begin
               phase_in       = PH_SPACE;
               result_in.kind = hhlp_pkg::KIND_SEP;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_SPACE: begin
            if (item.is_cr) begin
               phase_in = PH_ERROR;
            end else begin
               value_count_in = hhlp_pkg::VALUE_LEN_W'(1);
               phase_in       = PH_VALUE;
               result_in.kind = hhlp_pkg::KIND_VALUE;
            end
         end
         PH_VALUE: begin
            if (item.is_cr) begin
               phase_in       = PH_CR;
               result_in.kind = hhlp_pkg::KIND_SEP;
            end else if (cur_value > {1'b0, max_offset_ff}) begin
               phase_in = PH_ERROR;
            end else begin
               value_count_in = cur_value + 1'b1;
               result_in.kind = hhlp_pkg::KIND_VALUE;
            end
         end
         PH_CR: begin
            if (item.is_lf) begin
               phase_in            = PH_LF;
               result_in.kind      = hhlp_pkg::KIND_COMMIT;
               result_in.key_len   = hhlp_pkg::key_len_sat(cur_key);
               result_in.value_len = cur_value;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_LF: begin
            if (item.is_cr) begin
               phase_in       = PH_END_CR;
               result_in.kind = hhlp_pkg::KIND_SEP;
            end else if (item.is_lf) begin
               phase_in = PH_ERROR;
            end else begin
               key_count_in   = hhlp_pkg::KEY_COUNT_BITS'(1);
               value_count_in = '0;
               phase_in       = PH_KEY;
               result_in.kind = hhlp_pkg::KIND_KEY;
            end
         end
         PH_END_CR: begin
            if (item.is_lf) begin
               phase_in       = PH_DONE;
               result_in.kind = hhlp_pkg::KIND_DONE;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_DONE: begin
            result_in.kind = hhlp_pkg::KIND_BODY;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // Hold the result until the sink takes it
   always_comb begin
      if (pop) begin
         result_valid_in = 1'b1;
      end else if (result_ready) begin
         result_valid_in = 1'b0;
      end else begin
         result_valid_in = result_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         key_count_ff    <= '0;
         value_count_ff  <= '0;
         max_offset_ff   <= hhlp_pkg::MAX_OFFSET_INIT;
         result_valid_ff <= 1'b0;
      end else begin
         result_valid_ff <= result_valid_in;
         if (pop) begin
            phase_ff       <= phase_in;
            key_count_ff   <= key_count_in;
            value_count_ff <= value_count_in;
         end
         if (cfg_wr_en) begin
            max_offset_ff <= cfg_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   // A committed line always carries a non-empty key and value
   a_commit_len: assert property (@(posedge clock) disable iff (reset)
      (result_valid_ff && result_ff.kind == hhlp_pkg::KIND_COMMIT)
         |-> (result_ff.key_len != '0 && result_ff.value_len != '0))
      else $error("commit with empty key or value");

   // Lengths are reported on commits only
   a_len_only_commit: assert property (@(posedge clock) disable iff (reset)
      (result_valid_ff && result_ff.kind != hhlp_pkg::KIND_COMMIT)
         |-> (result_ff.key_len == '0 && result_ff.value_len == '0))
      else $error("length reported outside a commit");

   // Error phase is sticky until restart
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (pop && !item.restart && phase_ff == PH_ERROR)
         |=> (result_ff.kind == hhlp_pkg::KIND_ERROR && phase_ff == PH_ERROR))
      else $error("error phase left without restart");

   // Stepping always leaves a result to deliver
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> result_valid_ff)
      else $error("stepped byte without a result");

endmodule
